// ----- rtl/drc_pkg.sv -----
// ----------------------------------------------------------------------------
// drc_pkg: shared types and constants of the dirty rectangle coalescer.
// Holds command and status codes, register indexes, the sequencer states and
// the compare result group that the arithmetic unit reports.
// ----------------------------------------------------------------------------
package drc_pkg;

  // Default configuration of the store and coordinate width.
  localparam int CAPACITY_DEF   = 16;
  localparam int COORD_BITS_DEF = 16;

  // A get emits at most this many list entries.
  localparam int MAX_OUT = 16;

  // Register widths and reset values.
  localparam int              MAXR_W        = 5;
  localparam int              THR_W         = 10;
  localparam logic [MAXR_W-1:0] MAX_RECTS_RST = 5'd16;
  localparam logic [THR_W-1:0]  THR_RST       = 10'd179;
  localparam int              PADDR_W       = 3;
  localparam int              PDATA_W       = 32;

  // Commands of an input transaction.
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_GET = 2'd1,
    CMD_CLR = 2'd2
  } cmd_e;

  // Status of a result transaction.
  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_IGNORED = 3'd1,
    ST_FULL    = 3'd2,
    ST_LIST    = 3'd3,
    ST_DONE    = 3'd4
  } status_e;

  // Register select, taken from paddr bit 2.
  typedef enum logic {
    REG_MAX_RECTS = 1'b0,
    REG_THRESHOLD = 1'b1
  } reg_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_APPEND,
    S_OPT_START,
    S_OPT_COPY,
    S_OPT_COPY_W,
    S_SORT_LOAD,
    S_SORT_STEP,
    S_ENC_J,
    S_DROP,
    S_MRG_START,
    S_MRG_TEST,
    S_MRG_MUL,
    S_MRG_CMP,
    S_OPT_END,
    S_COPYBACK,
    S_GET_START,
    S_EMIT,
    S_RESP,
    S_OUT_WAIT
  } state_e;

  // Geometric relations between operand A and operand B.
  typedef struct packed {
    logic encl;  // B lies inside A
    logic ovl;   // A and B share interior area
  } cmp_t;

endpackage

// ----- rtl/dirty_rect_coalescer.sv -----
// ----------------------------------------------------------------------------
// dirty_rect_coalescer: dirty rectangle store with sort, prune and merge.
// An add that forces an optimization, or a stale get, also runs the optimization,
// whose time goes mostly to the merge passes that restart after each merge.
// One transaction is taken at a time; a get emits its entries one at a time, each
// one after out_ready_i has taken the last. Reset clears counts, flags and the
// configuration registers at once; the tables and payload registers are not reset.
// ----------------------------------------------------------------------------
module dirty_rect_coalescer #(
  parameter int CAPACITY   = drc_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = drc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic signed [COORD_BITS-1:0]  rect_x_i,
  input  logic signed [COORD_BITS-1:0]  rect_y_i,
  input  logic signed [COORD_BITS-1:0]  rect_width_i,
  input  logic signed [COORD_BITS-1:0]  rect_height_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic signed [COORD_BITS-1:0]  out_x_o,
  output logic signed [COORD_BITS-1:0]  out_y_o,
  output logic [COORD_BITS-1:0]         out_width_o,
  output logic [COORD_BITS-1:0]         out_height_o,
  output logic                          last_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drc_pkg::PADDR_W-1:0]   paddr,
  input  logic [drc_pkg::PDATA_W-1:0]   pwdata,
  output logic [drc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import drc_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = $clog2(CAPACITY);
  localparam int AW  = 2 * CB;
  localparam int MBW = (CB > THR_W) ? CB : THR_W;
  localparam int PW  = AW + MBW;

  // Configuration registers.
  logic [MAXR_W-1:0] maxr_q;
  logic [THR_W-1:0]  thr_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxr_q <= MAX_RECTS_RST;
      thr_q  <= THR_RST;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        REG_MAX_RECTS: maxr_q <= pwdata[MAXR_W-1:0];
        REG_THRESHOLD: thr_q  <= pwdata[THR_W-1:0];
        default:       maxr_q <= maxr_q;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_e'(paddr[2]))
      REG_MAX_RECTS: prdata = PDATA_W'(maxr_q);
      REG_THRESHOLD: prdata = PDATA_W'(thr_q);
      default:       prdata = '0;
    endcase
  end

  // Control state.
  state_e          state_q, state_d, drop_ret_q, drop_ret_d;
  logic [CW-1:0]   raw_cnt_q, raw_cnt_d, mrg_cnt_q, mrg_cnt_d;
  logic [CW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic            stale_q, stale_d, ret_add_q, ret_add_d;
  logic            out_valid_q, out_valid_d;

  // Payload state.
  logic signed [CB-1:0] raw_x_q [CAPACITY];
  logic signed [CB-1:0] raw_y_q [CAPACITY];
  logic [CB-1:0]        raw_w_q [CAPACITY];
  logic [CB-1:0]        raw_h_q [CAPACITY];
  logic signed [CB-1:0] raw_x_d [CAPACITY];
  logic signed [CB-1:0] raw_y_d [CAPACITY];
  logic [CB-1:0]        raw_w_d [CAPACITY];
  logic [CB-1:0]        raw_h_d [CAPACITY];
  logic signed [CB-1:0] mrg_x_q [CAPACITY];
  logic signed [CB-1:0] mrg_y_q [CAPACITY];
  logic [CB-1:0]        mrg_w_q [CAPACITY];
  logic [CB-1:0]        mrg_h_q [CAPACITY];
  logic [AW-1:0]        area_q  [CAPACITY];
  logic signed [CB-1:0] mrg_x_d [CAPACITY];
  logic signed [CB-1:0] mrg_y_d [CAPACITY];
  logic [CB-1:0]        mrg_w_d [CAPACITY];
  logic [CB-1:0]        mrg_h_d [CAPACITY];
  logic [AW-1:0]        area_d  [CAPACITY];

  logic signed [CB-1:0] r_x_q, r_x_d, r_y_q, r_y_d, c_x_q, c_x_d, c_y_q, c_y_d;
  logic signed [CB-1:0] u_x_q, u_x_d, u_y_q, u_y_d;
  logic [CB-1:0]        r_w_q, r_w_d, r_h_q, r_h_d, c_w_q, c_w_d, c_h_q, c_h_d;
  logic [CB-1:0]        u_w_q, u_w_d, u_h_q, u_h_d;
  logic [AW-1:0]        c_area_q, c_area_d, ua_q, ua_d;
  status_e              resp_q, resp_d, out_status_q, out_status_d;
  logic signed [CB-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [CB-1:0]        out_w_q, out_w_d, out_h_q, out_h_d;
  logic                 out_last_q, out_last_d;

  // Unit operands and results.
  logic signed [CB-1:0] a_x, a_y, b_x, b_y, bnd_x, bnd_y;
  logic [CB-1:0]        a_w, a_h, b_w, b_h, bnd_w, bnd_h;
  logic [AW-1:0]        mul_a;
  logic [MBW-1:0]       mul_b;
  logic [PW-1:0]        prod;
  cmp_t                 cmp;

  // Indexes and derived conditions.
  logic [IW-1:0] ii, jj, kk, jm1, kp1, rr;
  logic [7:0]    cnt8, rcnt8, i8, j8, k8, nout8;
  logic          in_acc, out_acc, in_empty, sort_shift, worth;
  logic [PW-1:0] lhs;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;

  always_comb begin
    ii    = i_q[IW-1:0];
    jj    = j_q[IW-1:0];
    kk    = k_q[IW-1:0];
    rr    = raw_cnt_q[IW-1:0];
    jm1   = IW'(j_q - CW'(1));
    kp1   = IW'(k_q + CW'(1));
    cnt8  = 8'(mrg_cnt_q);
    rcnt8 = 8'(raw_cnt_q);
    i8    = 8'(i_q);
    j8    = 8'(j_q);
    k8    = 8'(k_q);
    nout8 = (cnt8 > 8'(MAX_OUT)) ? 8'(MAX_OUT) : cnt8;
    in_empty   = (rect_width_i <= 0) || (rect_height_i <= 0);
    sort_shift = (j_q != '0) && (area_q[jm1] < c_area_q);
    lhs   = PW'({(AW + 1)'(area_q[ii]) + (AW + 1)'(area_q[jj]), 8'h00});
    worth = (ua_q == '0) ? (thr_q == '0) : (lhs >= prod);
  end

  // Operand selection for the shared unit.
  always_comb begin
    a_x = mrg_x_q[ii]; a_y = mrg_y_q[ii]; a_w = mrg_w_q[ii]; a_h = mrg_h_q[ii];
    b_x = mrg_x_q[jj]; b_y = mrg_y_q[jj]; b_w = mrg_w_q[jj]; b_h = mrg_h_q[jj];
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ADD_SCAN: begin
        a_x = raw_x_q[kk]; a_y = raw_y_q[kk]; a_w = raw_w_q[kk]; a_h = raw_h_q[kk];
        b_x = r_x_q; b_y = r_y_q; b_w = r_w_q; b_h = r_h_q;
      end
      S_ENC_J: begin
        a_x = mrg_x_q[jj]; a_y = mrg_y_q[jj]; a_w = mrg_w_q[jj]; a_h = mrg_h_q[jj];
        b_x = mrg_x_q[ii]; b_y = mrg_y_q[ii]; b_w = mrg_w_q[ii]; b_h = mrg_h_q[ii];
      end
      S_OPT_COPY: begin
        mul_a = AW'(raw_w_q[kk]);
        mul_b = MBW'(raw_h_q[kk]);
      end
      S_MRG_TEST: begin
        mul_a = AW'(bnd_w);
        mul_b = MBW'(bnd_h);
      end
      S_MRG_MUL: begin
        mul_a = prod[AW-1:0];
        mul_b = MBW'(thr_q);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  drc_unit #(
    .COORD_BITS (CB),
    .MUL_A_W    (AW),
    .MUL_B_W    (MBW)
  ) u_unit (
    .clk_i   (clk_i),
    .a_x_i   (a_x),
    .a_y_i   (a_y),
    .a_w_i   (a_w),
    .a_h_i   (a_h),
    .b_x_i   (b_x),
    .b_y_i   (b_y),
    .b_w_i   (b_w),
    .b_h_i   (b_h),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .cmp_o   (cmp),
    .bnd_x_o (bnd_x),
    .bnd_y_o (bnd_y),
    .bnd_w_o (bnd_w),
    .bnd_h_o (bnd_h),
    .prod_o  (prod)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(command_i))
            CMD_ADD: state_d = in_empty ? S_RESP : S_ADD_SCAN;
            CMD_GET: state_d = stale_q ? S_OPT_START : S_GET_START;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (k8 == rcnt8)   state_d = S_ADD_APPEND;
        else if (cmp.encl) state_d = S_RESP;
      end
      S_ADD_APPEND: begin
        if (rcnt8 == 8'(CAPACITY))             state_d = S_RESP;
        else if (rcnt8 + 8'd1 >= 8'(maxr_q)) state_d = S_OPT_START;
        else                                   state_d = S_RESP;
      end
      S_OPT_START: state_d = (!stale_q || raw_cnt_q == '0) ? S_OPT_END : S_OPT_COPY;
      S_OPT_COPY:  state_d = S_OPT_COPY_W;
      S_OPT_COPY_W: begin
        if (k8 + 8'd1 == cnt8) state_d = (cnt8 > 8'd1) ? S_SORT_LOAD : S_MRG_START;
        else                   state_d = S_OPT_COPY;
      end
      S_SORT_LOAD: state_d = S_SORT_STEP;
      S_SORT_STEP: begin
        if (!sort_shift) state_d = (i8 + 8'd1 == cnt8) ? S_ENC_J : S_SORT_LOAD;
      end
      S_ENC_J: begin
        if (i8 == cnt8)                       state_d = S_MRG_START;
        else if ((j_q != i_q) && cmp.encl)    state_d = S_DROP;
      end
      S_DROP: begin
        if (!(k8 + 8'd1 < cnt8)) state_d = drop_ret_q;
      end
      S_MRG_START: state_d = (cnt8 <= 8'd1) ? S_OPT_END : S_MRG_TEST;
      S_MRG_TEST: begin
        if (j8 == cnt8) begin
          if (i8 + 8'd2 >= cnt8) state_d = S_OPT_END;
        end else if (cmp.ovl) begin
          state_d = S_MRG_MUL;
        end
      end
      S_MRG_MUL:   state_d = S_MRG_CMP;
      S_MRG_CMP:   state_d = worth ? S_DROP : S_MRG_TEST;
      S_OPT_END:   state_d = ret_add_q ? S_COPYBACK : S_GET_START;
      S_COPYBACK: begin
        if (k8 + 8'd1 == cnt8) state_d = S_RESP;
      end
      S_GET_START: state_d = (nout8 == 8'd0) ? S_RESP : S_EMIT;
      S_EMIT:      state_d = S_OUT_WAIT;
      S_RESP:      state_d = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (out_acc) state_d = out_last_q ? S_IDLE : S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and table updates for each state.
  always_comb begin
    raw_x_d = raw_x_q; raw_y_d = raw_y_q; raw_w_d = raw_w_q; raw_h_d = raw_h_q;
    mrg_x_d = mrg_x_q; mrg_y_d = mrg_y_q; mrg_w_d = mrg_w_q; mrg_h_d = mrg_h_q;
    area_d  = area_q;
    raw_cnt_d = raw_cnt_q; mrg_cnt_d = mrg_cnt_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    stale_d = stale_q; ret_add_d = ret_add_q; drop_ret_d = drop_ret_q;
    r_x_d = r_x_q; r_y_d = r_y_q; r_w_d = r_w_q; r_h_d = r_h_q;
    c_x_d = c_x_q; c_y_d = c_y_q; c_w_d = c_w_q; c_h_d = c_h_q; c_area_d = c_area_q;
    u_x_d = u_x_q; u_y_d = u_y_q; u_w_d = u_w_q; u_h_d = u_h_q; ua_d = ua_q;
    resp_d = resp_q;
    out_valid_d = out_valid_q; out_status_d = out_status_q;
    out_x_d = out_x_q; out_y_d = out_y_q; out_w_d = out_w_q; out_h_d = out_h_q;
    out_last_d = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          r_x_d = rect_x_i; r_y_d = rect_y_i;
          r_w_d = rect_width_i; r_h_d = rect_height_i;
          k_d = '0;
          resp_d = ST_IGNORED;
          case (cmd_e'(command_i))
            CMD_ADD: ret_add_d = 1'b1;
            CMD_GET: ret_add_d = 1'b0;
            CMD_CLR: begin
              raw_cnt_d = '0;
              mrg_cnt_d = '0;
              stale_d   = 1'b0;
              resp_d    = ST_DONE;
            end
            default: resp_d = ST_IGNORED;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (k8 != rcnt8) begin
          if (cmp.encl) resp_d = ST_IGNORED;
          else          k_d = k_q + CW'(1);
        end
      end
      S_ADD_APPEND: begin
        if (rcnt8 == 8'(CAPACITY)) begin
          resp_d = ST_FULL;
        end else begin
          raw_x_d[rr] = r_x_q; raw_y_d[rr] = r_y_q;
          raw_w_d[rr] = r_w_q; raw_h_d[rr] = r_h_q;
          raw_cnt_d = raw_cnt_q + CW'(1);
          stale_d = 1'b1;
          resp_d = ST_ADDED;
        end
      end
      S_OPT_START: begin
        mrg_cnt_d = raw_cnt_q;
        k_d = '0;
        if (!stale_q || raw_cnt_q == '0) mrg_cnt_d = mrg_cnt_q;
      end
      S_OPT_COPY: begin
        mrg_x_d[kk] = raw_x_q[kk]; mrg_y_d[kk] = raw_y_q[kk];
        mrg_w_d[kk] = raw_w_q[kk]; mrg_h_d[kk] = raw_h_q[kk];
      end
      S_OPT_COPY_W: begin
        area_d[kk] = prod[AW-1:0];
        k_d = k_q + CW'(1);
        i_d = CW'(1);
      end
      S_SORT_LOAD: begin
        c_x_d = mrg_x_q[ii]; c_y_d = mrg_y_q[ii];
        c_w_d = mrg_w_q[ii]; c_h_d = mrg_h_q[ii];
        c_area_d = area_q[ii];
        j_d = i_q;
      end
      S_SORT_STEP: begin
        if (sort_shift) begin
          mrg_x_d[jj] = mrg_x_q[jm1]; mrg_y_d[jj] = mrg_y_q[jm1];
          mrg_w_d[jj] = mrg_w_q[jm1]; mrg_h_d[jj] = mrg_h_q[jm1];
          area_d[jj]  = area_q[jm1];
          j_d = j_q - CW'(1);
        end else begin
          mrg_x_d[jj] = c_x_q; mrg_y_d[jj] = c_y_q;
          mrg_w_d[jj] = c_w_q; mrg_h_d[jj] = c_h_q;
          area_d[jj]  = c_area_q;
          if (i8 + 8'd1 == cnt8) begin
            i_d = '0;
            j_d = '0;
          end else begin
            i_d = i_q + CW'(1);
          end
        end
      end
      S_ENC_J: begin
        if (i8 != cnt8) begin
          if (j_q == i_q) begin
            i_d = i_q + CW'(1);
            j_d = '0;
          end else if (cmp.encl) begin
            k_d = i_q;
            j_d = '0;
            drop_ret_d = S_ENC_J;
          end else begin
            j_d = j_q + CW'(1);
          end
        end
      end
      S_DROP: begin
        if (k8 + 8'd1 < cnt8) begin
          mrg_x_d[kk] = mrg_x_q[kp1]; mrg_y_d[kk] = mrg_y_q[kp1];
          mrg_w_d[kk] = mrg_w_q[kp1]; mrg_h_d[kk] = mrg_h_q[kp1];
          area_d[kk]  = area_q[kp1];
          k_d = k_q + CW'(1);
        end else begin
          mrg_cnt_d = mrg_cnt_q - CW'(1);
        end
      end
      S_MRG_START: begin
        i_d = '0;
        j_d = CW'(1);
      end
      S_MRG_TEST: begin
        if (j8 == cnt8) begin
          i_d = i_q + CW'(1);
          j_d = i_q + CW'(2);
        end else if (cmp.ovl) begin
          u_x_d = bnd_x; u_y_d = bnd_y; u_w_d = bnd_w; u_h_d = bnd_h;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_MRG_MUL: ua_d = prod[AW-1:0];
      S_MRG_CMP: begin
        if (worth) begin
          mrg_x_d[ii] = u_x_q; mrg_y_d[ii] = u_y_q;
          mrg_w_d[ii] = u_w_q; mrg_h_d[ii] = u_h_q;
          area_d[ii]  = ua_q;
          k_d = j_q;
          drop_ret_d = S_MRG_START;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_OPT_END: begin
        stale_d = 1'b0;
        k_d = '0;
      end
      S_COPYBACK: begin
        raw_x_d[kk] = mrg_x_q[kk]; raw_y_d[kk] = mrg_y_q[kk];
        raw_w_d[kk] = mrg_w_q[kk]; raw_h_d[kk] = mrg_h_q[kk];
        k_d = k_q + CW'(1);
        if (k8 + 8'd1 == cnt8) raw_cnt_d = mrg_cnt_q;
      end
      S_GET_START: begin
        resp_d = ST_DONE;
        k_d = '0;
      end
      S_EMIT: begin
        out_valid_d  = 1'b1;
        out_status_d = ST_LIST;
        out_x_d = mrg_x_q[kk]; out_y_d = mrg_y_q[kk];
        out_w_d = mrg_w_q[kk]; out_h_d = mrg_h_q[kk];
        out_last_d = (k8 + 8'd1 == nout8);
      end
      S_RESP: begin
        out_valid_d  = 1'b1;
        out_status_d = resp_q;
        out_x_d = '0; out_y_d = '0; out_w_d = '0; out_h_d = '0;
        out_last_d = 1'b1;
      end
      S_OUT_WAIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          k_d = k_q + CW'(1);
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      drop_ret_q  <= S_IDLE;
      raw_cnt_q   <= '0;
      mrg_cnt_q   <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      stale_q     <= 1'b0;
      ret_add_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      drop_ret_q  <= drop_ret_d;
      raw_cnt_q   <= raw_cnt_d;
      mrg_cnt_q   <= mrg_cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      stale_q     <= stale_d;
      ret_add_q   <= ret_add_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Tables and payload registers.
  always_ff @(posedge clk_i) begin
    raw_x_q <= raw_x_d; raw_y_q <= raw_y_d; raw_w_q <= raw_w_d; raw_h_q <= raw_h_d;
    mrg_x_q <= mrg_x_d; mrg_y_q <= mrg_y_d; mrg_w_q <= mrg_w_d; mrg_h_q <= mrg_h_d;
    area_q  <= area_d;
    r_x_q <= r_x_d; r_y_q <= r_y_d; r_w_q <= r_w_d; r_h_q <= r_h_d;
    c_x_q <= c_x_d; c_y_q <= c_y_d; c_w_q <= c_w_d; c_h_q <= c_h_d;
    c_area_q <= c_area_d;
    u_x_q <= u_x_d; u_y_q <= u_y_d; u_w_q <= u_w_d; u_h_q <= u_h_d;
    ua_q <= ua_d;
    resp_q <= resp_d;
    out_status_q <= out_status_d;
    out_x_q <= out_x_d; out_y_q <= out_y_d; out_w_q <= out_w_d; out_h_q <= out_h_d;
    out_last_q <= out_last_d;
  end

  // Ports.
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_width_o  = out_w_q;
  assign out_height_o = out_h_q;
  assign last_o       = out_last_q;

  // A new transaction is never taken while a result still waits.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while a result is pending");

  // The raw table never holds more than its capacity.
  a_raw_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    8'(raw_cnt_q) <= 8'(CAPACITY))
    else $error("raw count beyond capacity");

  // A list entry is only shown while the optimized table holds entries.
  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_q == ST_LIST) |-> (mrg_cnt_q != '0))
    else $error("list entry from an empty table");

endmodule

// ----- rtl/drc_unit.sv -----
// ----------------------------------------------------------------------------
// drc_unit: shared arithmetic unit of the coalescer.
// Compares two rectangles (enclosure and overlap), forms their saturated
// bounding box, and runs one registered multiplier used for all areas and
// for the scaled threshold product.
// ----------------------------------------------------------------------------
module drc_unit #(
  parameter int COORD_BITS = 16,
  parameter int MUL_A_W    = 32,
  parameter int MUL_B_W    = 16
) (
  input  logic                          clk_i,
  input  logic signed [COORD_BITS-1:0]  a_x_i,
  input  logic signed [COORD_BITS-1:0]  a_y_i,
  input  logic        [COORD_BITS-1:0]  a_w_i,
  input  logic        [COORD_BITS-1:0]  a_h_i,
  input  logic signed [COORD_BITS-1:0]  b_x_i,
  input  logic signed [COORD_BITS-1:0]  b_y_i,
  input  logic        [COORD_BITS-1:0]  b_w_i,
  input  logic        [COORD_BITS-1:0]  b_h_i,
  input  logic        [MUL_A_W-1:0]     mul_a_i,
  input  logic        [MUL_B_W-1:0]     mul_b_i,
  output drc_pkg::cmp_t                 cmp_o,
  output logic signed [COORD_BITS-1:0]  bnd_x_o,
  output logic signed [COORD_BITS-1:0]  bnd_y_o,
  output logic        [COORD_BITS-1:0]  bnd_w_o,
  output logic        [COORD_BITS-1:0]  bnd_h_o,
  output logic [MUL_A_W+MUL_B_W-1:0]    prod_o
);
  import drc_pkg::*;

  localparam int EW = COORD_BITS + 2;

  logic signed [EW-1:0] ax, ay, ar, ab, bx, by, br, bb;
  logic signed [EW-1:0] l, t, r, d, bw, bh, lim;
  logic [MUL_A_W+MUL_B_W-1:0] prod_q;

  // Edges of both operands at extended width.
  always_comb begin
    ax  = EW'(a_x_i);
    ay  = EW'(a_y_i);
    ar  = ax + $signed({2'b00, a_w_i});
    ab  = ay + $signed({2'b00, a_h_i});
    bx  = EW'(b_x_i);
    by  = EW'(b_y_i);
    br  = bx + $signed({2'b00, b_w_i});
    bb  = by + $signed({2'b00, b_h_i});
    lim = $signed({2'b00, {COORD_BITS{1'b1}}});
  end

  // Enclosure and overlap; touching edges do not overlap.
  always_comb begin
    cmp_o.encl = (bx >= ax) && (by >= ay) && (br <= ar) && (bb <= ab);
    cmp_o.ovl  = (ax < br) && (bx < ar) && (ay < bb) && (by < ab);
  end

  // Bounding box with size saturated to the coordinate range.
  always_comb begin
    l  = (ax < bx) ? ax : bx;
    t  = (ay < by) ? ay : by;
    r  = (ar > br) ? ar : br;
    d  = (ab > bb) ? ab : bb;
    bw = r - l;
    bh = d - t;
    bnd_x_o = l[COORD_BITS-1:0];
    bnd_y_o = t[COORD_BITS-1:0];
    bnd_w_o = (bw > lim) ? {COORD_BITS{1'b1}} : bw[COORD_BITS-1:0];
    bnd_h_o = (bh > lim) ? {COORD_BITS{1'b1}} : bh[COORD_BITS-1:0];
  end

  // Shared multiplier, one product per cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_i * mul_b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Dirty rectangle coalescer testbench
// A driver sends add, get, clear and unknown commands through the input
// handshake. A monitor checks each result against a built-in model of the
// rectangle store, which covers sorting, enclosure removal and bounding-box
// merging. The run steps through several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import drc_pkg::*;

  localparam int CAP    = 16;
  localparam int CBITS  = 16;
  localparam int LIMIT  = 10000000;

  typedef struct {
    logic [1:0]        cmd;
    logic signed [15:0] x, y, w, h;
  } item_t;

  typedef struct {
    status_e    st;
    logic [15:0] x, y, w, h;
    logic       last;
  } res_t;

  typedef struct {
    longint x, y, w, h;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] command_i = '0;
  logic signed [CBITS-1:0] rect_x_i = '0, rect_y_i = '0, rect_width_i = '0, rect_height_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic signed [CBITS-1:0] out_x_o, out_y_o;
  logic [CBITS-1:0] out_width_o, out_height_o;
  logic last_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  item_t pending_items[$];
  res_t  expected_results[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_req_cnt = 0;
  int    hold_ack_cnt = 0;
  int    hold_left = 0;
  int    errors = 0;
  int    results_seen = 0;
  int    items_sent = 0;
  longint cycles = 0;

  // Model state of the rectangle store.
  box_t raw_tab[CAP];
  box_t mrg_tab[CAP];
  int   raw_n = 0;
  int   mrg_n = 0;
  bit   stale = 1'b0;
  int   lim_cfg = 16;
  int   thr_cfg = 179;

  dirty_rect_coalescer uut (.*);

  always #1 clk_i = ~clk_i;

  function automatic bit box_encloses(box_t o, box_t i);
    return i.x >= o.x && i.y >= o.y && i.x + i.w <= o.x + o.w && i.y + i.h <= o.y + o.h;
  endfunction

  function automatic bit box_overlaps(box_t a, box_t b);
    return a.x < b.x + b.w && b.x < a.x + a.w && a.y < b.y + b.h && b.y < a.y + a.h;
  endfunction

  function automatic longint unsigned box_area(box_t r);
    return longint'(r.w) * longint'(r.h);
  endfunction

  // Bounding box; an oversized side saturates to the coordinate range.
  function automatic box_t box_union(box_t a, box_t b);
    longint lim, l, t, r, d;
    box_t u;
    lim = (longint'(1) << CBITS) - 1;
    l = (a.x < b.x) ? a.x : b.x;
    t = (a.y < b.y) ? a.y : b.y;
    r = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
    d = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
    u.x = l;
    u.y = t;
    u.w = (r - l > lim) ? lim : r - l;
    u.h = (d - t > lim) ? lim : d - t;
    return u;
  endfunction

  function automatic bit merge_pays(box_t a, box_t b);
    longint unsigned ua;
    if (!box_overlaps(a, b)) return 1'b0;
    ua = box_area(box_union(a, b));
    if (ua == 0) return thr_cfg == 0;
    return (box_area(a) + box_area(b)) * 256 >= longint'(thr_cfg) * ua;
  endfunction

  function automatic void drop_merged(int k);
    for (int i = k; i + 1 < mrg_n; i++) mrg_tab[i] = mrg_tab[i + 1];
    mrg_n--;
  endfunction

  // Sort by area, strip enclosed entries, then merge pairs until none pays.
  function automatic void coalesce_store();
    int i, j;
    bit again, hit;
    box_t cur;
    if (!stale || raw_n == 0) return;
    mrg_tab = raw_tab;
    mrg_n = raw_n;
    if (mrg_n > 1) begin
      for (i = 1; i < mrg_n; i++) begin
        cur = mrg_tab[i];
        j = i;
        while (j > 0 && box_area(mrg_tab[j - 1]) < box_area(cur)) begin
          mrg_tab[j] = mrg_tab[j - 1];
          j--;
        end
        mrg_tab[j] = cur;
      end
      i = 0;
      while (i < mrg_n) begin
        hit = 1'b0;
        for (j = 0; j < i; j++) if (box_encloses(mrg_tab[j], mrg_tab[i])) hit = 1'b1;
        if (hit) drop_merged(i);
        else i++;
      end
    end
    again = 1'b1;
    while (again && mrg_n > 1) begin
      again = 1'b0;
      for (i = 0; i < mrg_n && !again; i++) begin
        for (j = i + 1; j < mrg_n && !again; j++) begin
          if (merge_pays(mrg_tab[i], mrg_tab[j])) begin
            mrg_tab[i] = box_union(mrg_tab[i], mrg_tab[j]);
            drop_merged(j);
            again = 1'b1;
          end
        end
      end
    end
    stale = 1'b0;
  endfunction

  function automatic void push_result(status_e st, box_t r, bit has_box, bit last);
    res_t e;
    e.st = st;
    e.x = has_box ? r.x[15:0] : '0;
    e.y = has_box ? r.y[15:0] : '0;
    e.w = has_box ? r.w[15:0] : '0;
    e.h = has_box ? r.h[15:0] : '0;
    e.last = last;
    expected_results.insert(expected_results.size(), e);
  endfunction

  // Predict the results of one accepted transaction.
  function automatic void coalesce_step(item_t it);
    box_t r, z;
    int n;
    bit encl;
    z = '{0, 0, 0, 0};
    case (it.cmd)
      CMD_ADD: begin
        r.x = it.x; r.y = it.y; r.w = it.w; r.h = it.h;
        encl = 1'b0;
        for (int i = 0; i < raw_n; i++) if (box_encloses(raw_tab[i], r)) encl = 1'b1;
        if (r.w <= 0 || r.h <= 0 || encl) push_result(ST_IGNORED, z, 0, 1);
        else if (raw_n >= CAP) push_result(ST_FULL, z, 0, 1);
        else begin
          raw_tab[raw_n] = r;
          raw_n++;
          stale = 1'b1;
          if (raw_n >= lim_cfg) begin
            coalesce_store();
            raw_tab = mrg_tab;
            raw_n = mrg_n;
          end
          push_result(ST_ADDED, z, 0, 1);
        end
      end
      CMD_GET: begin
        if (stale) coalesce_store();
        n = (mrg_n > MAX_OUT) ? MAX_OUT : mrg_n;
        if (n == 0) push_result(ST_DONE, z, 0, 1);
        for (int i = 0; i < n; i++) push_result(ST_LIST, mrg_tab[i], 1, i + 1 == n);
      end
      CMD_CLR: begin
        raw_n = 0;
        mrg_n = 0;
        stale = 1'b0;
        push_result(ST_DONE, z, 0, 1);
      end
      default: push_result(ST_IGNORED, z, 0, 1);
    endcase
  endfunction

  // Driver: offers queued items and predicts each accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        coalesce_step('{command_i, rect_x_i, rect_y_i, rect_width_i, rect_height_i});
        items_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          command_i     <= pending_items[0].cmd;
          rect_x_i      <= pending_items[0].x;
          rect_y_i      <= pending_items[0].y;
          rect_width_i  <= pending_items[0].w;
          rect_height_i <= pending_items[0].h;
          void'(pending_items.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result transaction and drives the receiver stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d", $time, status_o);
          errors++;
        end else begin
          if (status_o !== expected_results[0].st || out_x_o !== expected_results[0].x ||
              out_y_o !== expected_results[0].y || out_width_o !== expected_results[0].w ||
              out_height_o !== expected_results[0].h || last_o !== expected_results[0].last) begin
            $display("%0t: mismatch expected st=%0d x=%h y=%h w=%h h=%h last=%b", $time,
                     expected_results[0].st, expected_results[0].x, expected_results[0].y,
                     expected_results[0].w, expected_results[0].h, expected_results[0].last);
            $display("%0t:          actual st=%0d x=%h y=%h w=%h h=%h last=%b", $time,
                     status_o, out_x_o, out_y_o, out_width_o, out_height_o, last_o);
            errors++;
          end
          void'(expected_results.pop_front());
        end
      end
      if (hold_req_cnt != hold_ack_cnt || hold_left > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(reg_e idx, int value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MAX_RECTS) lim_cfg = value & 32'h1f;
    else thr_cfg = value & 32'h3ff;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic queue_item(logic [1:0] c, int x, int y, int w, int h);
    item_t it;
    it = '{c, 16'(x), 16'(y), 16'(w), 16'(h)};
    pending_items.insert(pending_items.size(), it);
  endtask

  // Mostly small clustered rectangles so that enclosure and merging happen often.
  task automatic queue_random(int count);
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 6)
        queue_item(CMD_ADD, $urandom, $urandom, $urandom, $urandom);
      else if (roll < 11)
        queue_item(CMD_ADD, $urandom_range(80) - 40, $urandom_range(80) - 40,
                   $urandom_range(20) - 15, $urandom_range(20) - 15);
      else if (roll < 22)
        queue_item(CMD_GET, $urandom, $urandom, $urandom, $urandom);
      else if (roll < 26)
        queue_item(CMD_CLR, $urandom, $urandom, $urandom, $urandom);
      else if (roll < 28)
        queue_item(2'd3, $urandom, $urandom, $urandom, $urandom);
      else
        queue_item(CMD_ADD, $urandom_range(80) - 40, $urandom_range(80) - 40,
                   $urandom_range(30, 1), $urandom_range(30, 1));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty sizes, extremes, enclosure, edge contact, get, clear, bad command.
    reg_write(REG_MAX_RECTS, 16);
    reg_write(REG_THRESHOLD, 0);
    queue_item(CMD_ADD, 0, 0, 0, 5);
    queue_item(CMD_ADD, 0, 0, 5, -5);
    queue_item(CMD_ADD, 0, 0, -32768, -32768);
    queue_item(CMD_GET, 0, 0, 0, 0);
    queue_item(CMD_ADD, 0, 0, 10, 10);
    queue_item(CMD_ADD, 2, 2, 3, 3);
    queue_item(CMD_ADD, 10, 0, 10, 10);
    queue_item(CMD_ADD, -32768, -32768, 32767, 32767);
    queue_item(CMD_ADD, 32767, 32767, 1, 1);
    queue_item(CMD_GET, 0, 0, 0, 0);
    queue_item(2'd3, -1, -1, -1, -1);
    queue_item(CMD_CLR, 0, 0, 0, 0);
    queue_item(CMD_GET, 0, 0, 0, 0);
    queue_item(CMD_ADD, 5, 5, 10, 10);
    queue_item(CMD_ADD, 0, 0, 8, 8);
    queue_item(CMD_GET, 0, 0, 0, 0);
    queue_item(CMD_CLR, 0, 0, 0, 0);
    wait_drained();

    // Limit above capacity: fill the store, with a chain whose union saturates.
    reg_write(REG_MAX_RECTS, 31);
    queue_item(CMD_ADD, -32768, 0, 32767, 10);
    queue_item(CMD_ADD, -100, 0, 32767, 10);
    queue_item(CMD_ADD, 32000, 0, 32767, 10);
    for (int i = 0; i < 14; i++) queue_item(CMD_ADD, i * 40, 1000, 10, 10);
    queue_item(CMD_GET, 0, 0, 0, 0);
    queue_item(CMD_CLR, 0, 0, 0, 0);
    wait_drained();

    // Limit zero, strict threshold, sender idling.
    reg_write(REG_MAX_RECTS, 0);
    reg_write(REG_THRESHOLD, 512);
    send_idle_pct = 49;
    queue_random(30);
    wait_drained();

    // Receiver stalling, with one long hold-off while items keep coming.
    reg_write(REG_MAX_RECTS, 1);
    reg_write(REG_THRESHOLD, 256);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    hold_req_cnt++;
    queue_random(30);
    wait_drained();

    // Both sides idling.
    reg_write(REG_MAX_RECTS, 5);
    reg_write(REG_THRESHOLD, 179);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    queue_random(30);
    wait_drained();

    // All threshold bits set, moderate limit, no idling.
    reg_write(REG_MAX_RECTS, 12);
    reg_write(REG_THRESHOLD, 1023);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(15);
    wait_drained();

    $display("Sent %0d transactions and checked %0d results over six register settings.",
             items_sent, results_seen);
    $display("Covered full store, saturated unions, edge contact and idle patterns.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/drc_pkg.sv
rtl/drc_unit.sv
rtl/dirty_rect_coalescer.sv
sim/tb_top.sv
